### design/kalman_angle_bias_filter_unit_macros.svh
// Assertion macros for the kalman angle/bias filter unit.
// Uses the clock and reset names of the including module.
`ifndef KALMAN_ANGLE_BIAS_FILTER_UNIT_MACROS_SVH
`define KALMAN_ANGLE_BIAS_FILTER_UNIT_MACROS_SVH
`ifndef SYNTH
`define KABF_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("kabf assertion failed");
`define KABF_ASSERT_IMP(lbl, ante, cons) `KABF_ASSERT(lbl, (ante) |-> (cons))
`define KABF_ASSERT_NEXT(lbl, ante, cons) `KABF_ASSERT(lbl, (ante) |=> (cons))
`else
`define KABF_ASSERT(lbl, prop)
`define KABF_ASSERT_IMP(lbl, ante, cons)
`define KABF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### design/kabf_pkg.sv
// Shared types, constants and functions of the kalman angle/bias filter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kabf_pkg;

   localparam logic FUNC_UPDATE = 1'b0;
   localparam logic FUNC_REINIT = 1'b1;

   localparam logic [1:0] CSR_ANGLE_NOISE   = 2'd0;
   localparam logic [1:0] CSR_BIAS_NOISE    = 2'd1;
   localparam logic [1:0] CSR_MEASURE_NOISE = 2'd2;

   localparam logic [23:0] ANGLE_NOISE_RESET   = 24'd16777;
   localparam logic [23:0] BIAS_NOISE_RESET    = 24'd50332;
   localparam logic [23:0] MEASURE_NOISE_RESET = 24'd503316;

   localparam logic signed [32:0] DEG_TO_RAD_Q32 = 33'sd74961321;

   typedef enum logic [4:0] {
      OP_RATE,
      OP_ANG_PRED,
      OP_P11DT,
      OP_INNER,
      OP_PAA_PRED,
      OP_PAB_PRED,
      OP_PBA_PRED,
      OP_PBB_PRED,
      OP_INNOV,
      OP_GAIN,
      OP_ANG_CORR,
      OP_BIAS_CORR,
      OP_PBB_CORR,
      OP_PBA_CORR,
      OP_PAB_CORR,
      OP_PAA_CORR,
      OP_OUT
   } op_type;

   typedef struct packed {
      logic   capture;
      logic   reinit;
      logic   issue;
      logic   div_start;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_busy;
   } sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [31:0] r;
      if (v > 68'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -68'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### design/kabf_div.sv
// Gain divider: two radix-2 restoring lanes sharing the innovation variance.
// Depends on kabf_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "kalman_angle_bias_filter_unit_macros.svh"
module kabf_div
   import kabf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] cov_a,
   input  wire logic signed [31:0] cov_b,
   input  wire logic        [23:0] mnoise,
   output logic                    done,
   output logic signed [31:0]      gain_a,
   output logic signed [31:0]      gain_b
);

   logic signed [32:0] s_sum;
   logic        [32:0] s_mag;
   logic        [32:0] a_neg, b_neg;
   logic        [31:0] a_mag, b_mag;

   logic        busy_ff, done_ff;
   logic [4:0]  cnt_ff;
   logic [32:0] d_ff;
   logic [33:0] rem_a_ff, rem_b_ff;
   logic [30:0] low_a_ff, low_b_ff, q_a_ff, q_b_ff;
   logic        ovf_a_ff, ovf_b_ff, neg_a_ff, neg_b_ff, zero_ff;
   logic signed [31:0] gain_a_ff, gain_b_ff;

   logic [33:0] trial_a, trial_b, rem_a_in, rem_b_in;
   logic        bit_a, bit_b;
   logic [30:0] q_a_in, q_b_in;

   function automatic logic signed [31:0] finish(input logic [30:0] q, input logic ovf,
                                                 input logic neg, input logic zero);
      logic signed [31:0] r;
      if (zero) begin
         r = 32'sd0;
      end else if (ovf) begin
         r = neg ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
         r = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
      end
      return r;
   endfunction

   always_comb begin
      s_sum = $signed({cov_a[31], cov_a}) + $signed({9'b0, mnoise});
      s_mag = s_sum[32] ? 33'(-s_sum) : s_sum;
      a_neg = 33'(-$signed({cov_a[31], cov_a}));
      b_neg = 33'(-$signed({cov_b[31], cov_b}));
      a_mag = cov_a[31] ? a_neg[31:0] : cov_a;
      b_mag = cov_b[31] ? b_neg[31:0] : cov_b;

      trial_a = {rem_a_ff[32:0], low_a_ff[30]};
      trial_b = {rem_b_ff[32:0], low_b_ff[30]};
      bit_a = trial_a >= {1'b0, d_ff};
      bit_b = trial_b >= {1'b0, d_ff};
      rem_a_in = bit_a ? trial_a - {1'b0, d_ff} : trial_a;
      rem_b_in = bit_b ? trial_b - {1'b0, d_ff} : trial_b;
      q_a_in = {q_a_ff[29:0], bit_a};
      q_b_in = {q_b_ff[29:0], bit_b};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd30) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         d_ff     <= s_mag;
         zero_ff  <= (s_sum == 33'sd0);
         rem_a_ff <= 34'(a_mag >> 7);
         rem_b_ff <= 34'(b_mag >> 7);
         low_a_ff <= {a_mag[6:0], 24'b0};
         low_b_ff <= {b_mag[6:0], 24'b0};
         ovf_a_ff <= {8'b0, a_mag[31:7]} >= s_mag;
         ovf_b_ff <= {8'b0, b_mag[31:7]} >= s_mag;
         neg_a_ff <= cov_a[31] ^ s_sum[32];
         neg_b_ff <= cov_b[31] ^ s_sum[32];
         q_a_ff   <= 31'd0;
         q_b_ff   <= 31'd0;
      end else if (busy_ff) begin
         rem_a_ff <= rem_a_in;
         rem_b_ff <= rem_b_in;
         low_a_ff <= {low_a_ff[29:0], 1'b0};
         low_b_ff <= {low_b_ff[29:0], 1'b0};
         q_a_ff   <= q_a_in;
         q_b_ff   <= q_b_in;
         if (cnt_ff == 5'd30) begin
            gain_a_ff <= finish(q_a_in, ovf_a_ff, neg_a_ff, zero_ff);
            gain_b_ff <= finish(q_b_in, ovf_b_ff, neg_b_ff, zero_ff);
         end
      end
   end

   assign done   = done_ff;
   assign gain_a = gain_a_ff;
   assign gain_b = gain_b_ff;

   `KABF_ASSERT_NEXT(a_div_no_early_done, start, !done_ff)
   `KABF_ASSERT_IMP(a_div_done_ends_busy, done_ff, !busy_ff)
   `KABF_ASSERT_IMP(a_div_count_bound, busy_ff, cnt_ff <= 5'd30)

endmodule
`default_nettype wire

### design/kabf_dp.sv
// Datapath: filter state, shared multiply/round/saturate unit, gain divider,
// result register. Depends on kabf_pkg and kabf_div.
`timescale 1ns / 1ps
`default_nettype none
module kabf_dp
   import kabf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output sts_type                 sts,
   input  wire logic signed [31:0] req_accel_angle,
   input  wire logic signed [31:0] req_gyro_rate,
   input  wire logic        [15:0] req_elapsed,
   input  wire logic        [23:0] angle_noise,
   input  wire logic        [23:0] bias_noise,
   input  wire logic        [23:0] measure_noise,
   input  wire logic               rsp_stall,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_angle_rad
);

   localparam logic [1:0] SHIFT_16 = 2'd0;
   localparam logic [1:0] SHIFT_24 = 2'd1;
   localparam logic [1:0] SHIFT_32 = 2'd2;
   localparam logic signed [32:0] ONE_Q16 = 33'sd65536;

   logic signed [31:0] ang_ff, bias_ff, paa_ff, pab_ff, pba_ff, pbb_ff;
   logic signed [31:0] meas_ff, gyro_ff, rate_ff, p11dt_ff, inner_ff, y_ff, res_ff;
   logic        [15:0] dt_ff;
   logic               rsp_valid_ff, wb_ff;
   op_type             op_ff;
   logic signed [65:0] prod_ff;

   logic signed [32:0] opa, opb, dt_ext;
   logic signed [33:0] addend;
   logic               sub;
   logic [1:0]         shift_sel;
   logic signed [66:0] prod_ext, rnd16, rnd24, rnd32, rnd_val;
   logic signed [67:0] total;
   logic signed [31:0] wb_val;
   logic               div_done;
   logic signed [31:0] k0, k1;

   kabf_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.div_start),
      .cov_a  (paa_ff),
      .cov_b  (pba_ff),
      .mnoise (measure_noise),
      .done   (div_done),
      .gain_a (k0),
      .gain_b (k1)
   );

   always_comb begin
      dt_ext = $signed({17'b0, dt_ff});
      opa = 33'sd0;
      opb = 33'sd0;
      case (cmd.op)
         OP_RATE:      begin opa = 33'(bias_ff); opb = ONE_Q16; end
         OP_ANG_PRED:  begin opa = dt_ext; opb = 33'(rate_ff); end
         OP_P11DT:     begin opa = dt_ext; opb = 33'(pbb_ff); end
         OP_INNER:     begin
            opa = $signed({pab_ff[31], pab_ff}) + $signed({pba_ff[31], pba_ff});
            opb = ONE_Q16;
         end
         OP_PAA_PRED:  begin opa = dt_ext; opb = 33'(inner_ff); end
         OP_PAB_PRED,
         OP_PBA_PRED:  begin opa = 33'(p11dt_ff); opb = ONE_Q16; end
         OP_PBB_PRED:  begin opa = dt_ext; opb = $signed({9'b0, bias_noise}); end
         OP_INNOV:     begin opa = 33'(ang_ff); opb = ONE_Q16; end
         OP_ANG_CORR:  begin opa = 33'(k0); opb = 33'(y_ff); end
         OP_BIAS_CORR: begin opa = 33'(k1); opb = 33'(y_ff); end
         OP_PBB_CORR:  begin opa = 33'(k1); opb = 33'(pab_ff); end
         OP_PBA_CORR:  begin opa = 33'(k1); opb = 33'(paa_ff); end
         OP_PAB_CORR:  begin opa = 33'(k0); opb = 33'(pab_ff); end
         OP_PAA_CORR:  begin opa = 33'(k0); opb = 33'(paa_ff); end
         OP_OUT:       begin opa = 33'(ang_ff); opb = DEG_TO_RAD_Q32; end
         default:      begin opa = 33'sd0; opb = 33'sd0; end
      endcase
   end

   always_comb begin
      addend    = 34'sd0;
      sub       = 1'b0;
      shift_sel = SHIFT_16;
      case (op_ff)
         OP_RATE:      begin addend = 34'(gyro_ff); sub = 1'b1; end
         OP_ANG_PRED:  begin addend = 34'(ang_ff); end
         OP_P11DT:     begin addend = 34'sd0; end
         OP_INNER:     begin
            addend = $signed({{2{p11dt_ff[31]}}, p11dt_ff}) + $signed({10'b0, angle_noise});
            sub = 1'b1;
         end
         OP_PAA_PRED:  begin addend = 34'(paa_ff); end
         OP_PAB_PRED:  begin addend = 34'(pab_ff); sub = 1'b1; end
         OP_PBA_PRED:  begin addend = 34'(pba_ff); sub = 1'b1; end
         OP_PBB_PRED:  begin addend = 34'(pbb_ff); end
         OP_INNOV:     begin addend = 34'(meas_ff); sub = 1'b1; end
         OP_ANG_CORR:  begin addend = 34'(ang_ff); shift_sel = SHIFT_24; end
         OP_BIAS_CORR: begin addend = 34'(bias_ff); shift_sel = SHIFT_24; end
         OP_PBB_CORR:  begin addend = 34'(pbb_ff); sub = 1'b1; shift_sel = SHIFT_24; end
         OP_PBA_CORR:  begin addend = 34'(pba_ff); sub = 1'b1; shift_sel = SHIFT_24; end
         OP_PAB_CORR:  begin addend = 34'(pab_ff); sub = 1'b1; shift_sel = SHIFT_24; end
         OP_PAA_CORR:  begin addend = 34'(paa_ff); sub = 1'b1; shift_sel = SHIFT_24; end
         OP_OUT:       begin addend = 34'sd0; shift_sel = SHIFT_32; end
         default:      begin addend = 34'sd0; end
      endcase

      prod_ext = {prod_ff[65], prod_ff};
      rnd16 = (prod_ext + (67'sd1 <<< 15)) >>> 16;
      rnd24 = (prod_ext + (67'sd1 <<< 23)) >>> 24;
      rnd32 = (prod_ext + (67'sd1 <<< 31)) >>> 32;
      case (shift_sel)
         SHIFT_24: rnd_val = rnd24;
         SHIFT_32: rnd_val = rnd32;
         default:  rnd_val = rnd16;
      endcase
      total  = sub ? 68'(addend) - 68'(rnd_val) : 68'(addend) + 68'(rnd_val);
      wb_val = sat32(total);
   end

   always_ff @(posedge clock) begin
      prod_ff <= opa * opb;
      op_ff   <= cmd.op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wb_ff <= cmd.issue;
         if (wb_ff && op_ff == OP_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_ff  <= 32'sd0;
         bias_ff <= 32'sd0;
         paa_ff  <= 32'sd0;
         pab_ff  <= 32'sd0;
         pba_ff  <= 32'sd0;
         pbb_ff  <= 32'sd0;
      end else if (cmd.reinit) begin
         ang_ff  <= req_accel_angle;
         bias_ff <= 32'sd0;
         paa_ff  <= 32'sd0;
         pab_ff  <= 32'sd0;
         pba_ff  <= 32'sd0;
         pbb_ff  <= 32'sd0;
      end else if (wb_ff) begin
         case (op_ff)
            OP_ANG_PRED,
            OP_ANG_CORR:  ang_ff  <= wb_val;
            OP_BIAS_CORR: bias_ff <= wb_val;
            OP_PAA_PRED,
            OP_PAA_CORR:  paa_ff  <= wb_val;
            OP_PAB_PRED,
            OP_PAB_CORR:  pab_ff  <= wb_val;
            OP_PBA_PRED,
            OP_PBA_CORR:  pba_ff  <= wb_val;
            OP_PBB_PRED,
            OP_PBB_CORR:  pbb_ff  <= wb_val;
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         meas_ff <= req_accel_angle;
         gyro_ff <= req_gyro_rate;
         dt_ff   <= req_elapsed;
      end
      if (wb_ff) begin
         case (op_ff)
            OP_RATE:  rate_ff  <= wb_val;
            OP_P11DT: p11dt_ff <= wb_val;
            OP_INNER: inner_ff <= wb_val;
            OP_INNOV: y_ff     <= wb_val;
            OP_OUT:   res_ff   <= wb_val;
            default:  ;
         endcase
      end
   end

   assign sts.div_done  = div_done;
   assign sts.out_busy  = rsp_valid_ff && rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_angle_rad = res_ff;

endmodule
`default_nettype wire

### design/kabf_ctrl.sv
// Controller: sequences the update steps over the datapath.
// Depends on kabf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "kalman_angle_bias_filter_unit_macros.svh"
module kabf_ctrl
   import kabf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_func,
   output logic         req_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_DIV_WAIT} state_type;

   state_type state_ff;
   op_type    step_ff;
   logic      accept;
   op_type    step_next;

   always_comb begin
      accept    = (state_ff == ST_IDLE) && req_valid;
      req_stall = (state_ff != ST_IDLE);
      step_next = op_type'(5'(step_ff + 5'd1));
      cmd.capture   = accept;
      cmd.reinit    = accept && (req_func == FUNC_REINIT);
      cmd.op        = step_ff;
      cmd.issue     = 1'b0;
      cmd.div_start = 1'b0;
      if (state_ff == ST_ISSUE) begin
         if (step_ff == OP_GAIN) begin
            cmd.div_start = 1'b1;
         end else if (!(step_ff == OP_OUT && sts.out_busy)) begin
            cmd.issue = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= OP_RATE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && req_func == FUNC_UPDATE) begin
                  step_ff  <= OP_RATE;
                  state_ff <= ST_ISSUE;
               end
            end
            ST_ISSUE: begin
               if (cmd.div_start) begin
                  state_ff <= ST_DIV_WAIT;
               end else if (cmd.issue) begin
                  state_ff <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               if (step_ff == OP_OUT) begin
                  state_ff <= ST_IDLE;
               end else begin
                  step_ff  <= step_next;
                  state_ff <= ST_ISSUE;
               end
            end
            ST_DIV_WAIT: begin
               if (sts.div_done) begin
                  step_ff  <= step_next;
                  state_ff <= ST_ISSUE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `KABF_ASSERT_IMP(a_out_slot_free, cmd.issue && cmd.op == OP_OUT, !sts.out_busy)
   `KABF_ASSERT_IMP(a_done_in_wait, sts.div_done, state_ff == ST_DIV_WAIT)
   `KABF_ASSERT_NEXT(a_update_holds_off, accept && req_func == FUNC_UPDATE, req_stall)

endmodule
`default_nettype wire

### design/kalman_angle_bias_filter_unit.sv
// Two-state (angle, gyro bias) Kalman filter unit.
// Input channel req_*: func selects update or reinit; a transfer takes place when
// req_valid is high and req_stall low. Result channel rsp_*: one angle_rad
// transfer per update, none per reinit, taken when rsp_valid is high and
// rsp_stall low.
// An update runs sixteen multiply steps through the one shared 33x33 multiplier
// with round and saturate, and a 31-step bit-serial divide for the two gains
// that holds the sequence until it is done. One item is in work at a time, so
// no new request is taken until an update is through; a reinit is done once
// it is taken, and the unit stays idle. The result sits in an output
// register: the next item is taken while it waits, and an update only stalls
// at its final step while the receiver holds rsp_stall with a result pending.
// Noise registers sit on an APB-style port at byte addresses 0, 4 and 8.
// Synchronous reset clears the filter state to zero, loads the default noise
// values and drops rsp_valid.
// Depends on kabf_pkg, kabf_ctrl and kabf_dp.
`timescale 1ns / 1ps
`default_nettype none
module kalman_angle_bias_filter_unit
   import kabf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_func,
   input  wire logic signed [31:0] req_accel_angle,
   input  wire logic signed [31:0] req_gyro_rate,
   input  wire logic        [15:0] req_elapsed,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_angle_rad,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic        [3:0]  csr_paddr,
   input  wire logic        [31:0] csr_pwdata,
   output logic             [31:0] csr_prdata,
   output logic                    csr_pready
);

   logic [23:0] angle_noise_ff, bias_noise_ff, measure_noise_ff;
   cmd_type     cmd;
   sts_type     sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_noise_ff   <= ANGLE_NOISE_RESET;
         bias_noise_ff    <= BIAS_NOISE_RESET;
         measure_noise_ff <= MEASURE_NOISE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[3:2])
            CSR_ANGLE_NOISE:   angle_noise_ff   <= csr_pwdata[23:0];
            CSR_BIAS_NOISE:    bias_noise_ff    <= csr_pwdata[23:0];
            CSR_MEASURE_NOISE: measure_noise_ff <= csr_pwdata[23:0];
            default:           ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         CSR_ANGLE_NOISE:   csr_prdata = {8'b0, angle_noise_ff};
         CSR_BIAS_NOISE:    csr_prdata = {8'b0, bias_noise_ff};
         CSR_MEASURE_NOISE: csr_prdata = {8'b0, measure_noise_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready = 1'b1;

   kabf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   kabf_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_accel_angle (req_accel_angle),
      .req_gyro_rate   (req_gyro_rate),
      .req_elapsed     (req_elapsed),
      .angle_noise     (angle_noise_ff),
      .bias_noise      (bias_noise_ff),
      .measure_noise   (measure_noise_ff),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_angle_rad   (rsp_angle_rad)
   );

endmodule
`default_nettype wire
